// ===== hdl/wsdf_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  // Port widths.
  localparam int RX_BYTE_W   = 8;
  localparam int M_TDATA_W   = 48;
  localparam int M_TUSER_W   = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;

  // Field widths.
  localparam int OPCODE_W    = 4;
  localparam int LEN_W       = 32;
  localparam int EXT_LEN_W   = 64;
  localparam int KEY_W       = 32;
  localparam int HCOUNT_W    = 3;

  // Codes of the 7-bit length field that announce an extended length.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header byte counts that end each extended part. The 64-bit length
  // takes eight bytes, so the three-bit count wraps back to zero.
  localparam logic [HCOUNT_W-1:0] NEED_EXT16 = 3'd2;
  localparam logic [HCOUNT_W-1:0] NEED_EXT64 = 3'd0;
  localparam logic [HCOUNT_W-1:0] NEED_MASK  = 3'd4;

  // Register reset values.
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 32'd4096;
  localparam logic             ENABLED_RESET     = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_PAYLOAD = 1'b0,
    REG_ENABLED     = 1'b1
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_DISABLED = 2'd2
  } status_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_MASK    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

endpackage

// ===== hdl/websocket_frame_deframer.sv =====
// WebSocket receive-side frame deframer: header parsing and payload unmasking.
//
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  tdata[7:0] rx_byte
// m_axis    out  m_tvalid/m_tready  tdata: data_byte, frame_opcode, frame_length;
//                                   tuser: has_data, status; tlast: last
// cfg       in   cfg_we             cfg_index, cfg_wdata (max_payload, enabled)
//
// One byte is accepted per cycle while s_tready is high; its result, if any,
// appears in the output register on the next cycle. The parser state and
// result logic sit between the input port and that single output register.
// A byte is still accepted while a result waits, as long as m_tready is high.
// rst is synchronous and returns the parser to the first header byte and the
// registers to max_payload = 4096, enabled = 1.
module websocket_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream: tdata[7:0] rx_byte.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wsdf_pkg::RX_BYTE_W-1:0]    s_tdata,
  // Output stream: tdata[7:0] data_byte, [11:8] frame_opcode,
  // [43:12] frame_length, [47:44] zero.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wsdf_pkg::M_TDATA_W-1:0]    m_tdata,
  // tuser[0] has_data, [2:1] status.
  output logic [wsdf_pkg::M_TUSER_W-1:0]    m_tuser,
  output logic                              m_tlast,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [wsdf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wsdf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wsdf_pkg::*;

  // Configuration registers.
  logic [LEN_W-1:0]     max_payload;
  logic                 enabled;

  // Parser state.
  phase_t               phase, phase_next;
  logic [OPCODE_W-1:0]  opcode_reg, opcode_reg_next;
  logic                 mask_flag, mask_flag_next;
  logic [EXT_LEN_W-1:0] length_reg, length_reg_next;
  logic [HCOUNT_W-1:0]  hcount, hcount_next;
  logic [KEY_W-1:0]     mask_key, mask_key_next;
  logic [LEN_W-1:0]     payload_index, payload_index_next;
  logic                 sticky_error, sticky_error_next;

  // Result of the current byte.
  logic                 res_valid;
  logic [7:0]           res_data;
  logic                 res_has_data;
  logic [OPCODE_W-1:0]  res_opcode;
  logic [LEN_W-1:0]     res_length;
  logic                 res_last;
  status_t              res_status;

  // Output register.
  logic                 out_valid;
  logic [7:0]           out_data;
  logic                 out_has_data;
  logic [OPCODE_W-1:0]  out_frame_op;
  logic [LEN_W-1:0]     out_length;
  logic                 out_last;
  status_t              out_status;

  logic                 accept;
  logic                 do_after_len;
  logic                 do_finish;
  logic [6:0]           len7;
  logic [7:0]           key_byte;
  logic [LEN_W-1:0]     index_inc;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign len7     = s_tdata[6:0];
  assign index_inc = payload_index + 32'd1;

  // Mask key byte for this payload position; the first key byte sits on top.
  always_comb begin
    case (payload_index[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Parser next state and result for one received byte.
  always_comb begin
    phase_next         = phase;
    opcode_reg_next    = opcode_reg;
    mask_flag_next     = mask_flag;
    length_reg_next    = length_reg;
    hcount_next        = hcount;
    mask_key_next      = mask_key;
    payload_index_next = payload_index;
    sticky_error_next  = sticky_error;
    res_valid          = 1'b0;
    res_data           = 8'd0;
    res_has_data       = 1'b0;
    res_opcode         = '0;
    res_length         = '0;
    res_last           = 1'b0;
    res_status         = STATUS_OK;
    do_after_len       = 1'b0;
    do_finish          = 1'b0;

    if (!enabled) begin
      // Disabled: flag the byte and leave the state alone.
      res_valid  = 1'b1;
      res_status = STATUS_DISABLED;
    end else if (!sticky_error) begin
      unique case (phase)
        PH_HDR0: begin
          opcode_reg_next = s_tdata[OPCODE_W-1:0];
          mask_key_next   = '0;
          length_reg_next = '0;
          hcount_next     = '0;
          phase_next      = PH_HDR1;
        end
        PH_HDR1: begin
          mask_flag_next  = s_tdata[7];
          hcount_next     = '0;
          length_reg_next = '0;
          if (len7 == LEN7_EXT16) begin
            phase_next = PH_EXT16;
          end else if (len7 == LEN7_EXT64) begin
            phase_next = PH_EXT64;
          end else begin
            length_reg_next = {57'd0, len7};
            do_after_len    = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          length_reg_next = {length_reg[EXT_LEN_W-9:0], s_tdata};
          hcount_next     = hcount + 3'd1;
          if (hcount_next == ((phase == PH_EXT16) ? NEED_EXT16 : NEED_EXT64)) begin
            do_after_len = 1'b1;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[KEY_W-9:0], s_tdata};
          hcount_next   = hcount + 3'd1;
          if (hcount_next == NEED_MASK) begin
            do_finish = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_valid          = 1'b1;
          res_data           = s_tdata ^ (mask_flag ? key_byte : 8'd0);
          res_has_data       = 1'b1;
          res_opcode         = opcode_reg;
          res_length         = length_reg[LEN_W-1:0];
          res_last           = (index_inc == length_reg[LEN_W-1:0]);
          payload_index_next = index_inc;
          if (res_last) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Length known: either collect the mask key or close the header.
      if (do_after_len) begin
        hcount_next = '0;
        if (mask_flag_next) begin
          phase_next = PH_MASK;
        end else begin
          do_finish = 1'b1;
        end
      end

      // Header complete: overflow, empty frame or start of payload.
      if (do_finish) begin
        if ((length_reg_next[EXT_LEN_W-1:LEN_W] != '0) ||
            (length_reg_next[LEN_W-1:0] > max_payload)) begin
          res_valid         = 1'b1;
          res_opcode        = opcode_reg_next;
          res_length        = (length_reg_next[EXT_LEN_W-1:LEN_W] != '0) ?
                              '1 : length_reg_next[LEN_W-1:0];
          res_last          = 1'b1;
          res_status        = STATUS_OVERFLOW;
          sticky_error_next = 1'b1;
          phase_next        = PH_HDR0;
        end else if (length_reg_next == '0) begin
          res_valid  = 1'b1;
          res_opcode = opcode_reg_next;
          res_last   = 1'b1;
          phase_next = PH_HDR0;
        end else begin
          payload_index_next = '0;
          phase_next         = PH_PAYLOAD;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
      enabled     <= ENABLED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD: max_payload <= cfg_wdata;
        REG_ENABLED:     enabled     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Parser state update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      opcode_reg    <= '0;
      mask_flag     <= 1'b0;
      length_reg    <= '0;
      hcount        <= '0;
      mask_key      <= '0;
      payload_index <= '0;
      sticky_error  <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      opcode_reg    <= opcode_reg_next;
      mask_flag     <= mask_flag_next;
      length_reg    <= length_reg_next;
      hcount        <= hcount_next;
      mask_key      <= mask_key_next;
      payload_index <= payload_index_next;
      sticky_error  <= sticky_error_next;
    end
  end

  // Output register: refilled whenever the previous result is gone or taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data     <= res_data;
      out_has_data <= res_has_data;
      out_frame_op <= res_opcode;
      out_length   <= res_length;
      out_last     <= res_last;
      out_status   <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_length, out_frame_op, out_data};
  assign m_tuser  = {out_status, out_has_data};
  assign m_tlast  = out_last;

  // A payload byte is only ever delivered with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_has_data |-> out_status == STATUS_OK)
    else $error("payload byte delivered with error status");

  // A result without payload carries a zero data byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_has_data |-> out_data == 8'd0)
    else $error("nonzero data byte without payload");

  // The error state holds until reset.
  assert property (@(posedge clk) disable iff (rst)
    sticky_error |=> sticky_error)
    else $error("sticky error cleared without reset");

  // Within a payload the byte index stays below the frame length.
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_index < length_reg[LEN_W-1:0] && !sticky_error)
    else $error("payload index beyond frame length");

endmodule

// ===== dv/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for the WebSocket frame deframer.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsdf_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_ITEMS   = 300;
  localparam int SEGMENT_ITEMS  = 80;
  localparam int HOLD_CYCLES    = 300;
  localparam int FRAME_CAP      = 200;
  localparam int NOISE_MIN_MAX  = 255;

  // Extended length forms of a generated header.
  localparam int EXT_NONE = 0;
  localparam int EXT_16   = 16;
  localparam int EXT_64   = 64;

  // Header bytes that complete each extended part.
  localparam int EXT16_BYTES = 2;
  localparam int EXT64_BYTES = 8;
  localparam int KEY_BYTES   = 4;

  typedef enum logic [2:0] {
    WAIT_HDR0,
    WAIT_HDR1,
    WAIT_EXT16,
    WAIT_EXT64,
    WAIT_KEY,
    IN_PAYLOAD
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic [3:0]  opcode;
    logic [31:0] length;
    logic        last;
    status_t     status;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [RX_BYTE_W-1:0]   s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the deframer state and its registers.
  parse_state_t parse_phase = WAIT_HDR0;
  logic [3:0]   hdr_opcode  = '0;
  logic         masked      = 1'b0;
  logic [63:0]  frame_len_q = '0;
  int           hdr_count   = 0;
  logic [31:0]  key_q       = '0;
  logic [31:0]  pay_idx     = '0;
  logic         sticky      = 1'b0;
  logic [31:0]  max_bytes   = MAX_PAYLOAD_RESET;
  logic         rx_enabled  = ENABLED_RESET;

  frame_result_t pending_results[$];
  int fail_count  = 0;
  int bytes_sent  = 0;
  bit src_gaps    = 1'b0;
  bit sink_throttle = 1'b0;
  int sink_hold_req = 0;
  int hold_left   = 0;
  int stall_left  = 0;

  websocket_frame_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Header complete: overflow, empty frame, or start of the payload.
  function automatic bit close_header(output frame_result_t r);
    r = '0;
    if (frame_len_q > {32'd0, max_bytes}) begin
      r.opcode = hdr_opcode;
      r.length = (frame_len_q[63:32] != '0) ? 32'hFFFF_FFFF : frame_len_q[31:0];
      r.last   = 1'b1;
      r.status = STATUS_OVERFLOW;
      sticky = 1'b1;
      parse_phase = WAIT_HDR0;
      return 1'b1;
    end
    if (frame_len_q == '0) begin
      r.opcode = hdr_opcode;
      r.last   = 1'b1;
      r.status = STATUS_OK;
      parse_phase = WAIT_HDR0;
      return 1'b1;
    end
    pay_idx = '0;
    parse_phase = IN_PAYLOAD;
    return 1'b0;
  endfunction

  // Length known: a masked frame still has its key to come.
  function automatic bit length_done(output frame_result_t r);
    r = '0;
    hdr_count = 0;
    if (masked) begin
      parse_phase = WAIT_KEY;
      return 1'b0;
    end
    return close_header(r);
  endfunction

  // Advances the shadow parser by one accepted byte; returns 1 with a result.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_result_t r);
    logic [7:0] key_byte;
    logic       last_byte;
    int         shift;
    r = '0;
    if (!rx_enabled) begin
      r.status = STATUS_DISABLED;
      return 1'b1;
    end
    if (sticky) return 1'b0;
    case (parse_phase)
      WAIT_HDR0: begin
        hdr_opcode  = b[3:0];
        key_q       = '0;
        frame_len_q = '0;
        hdr_count   = 0;
        parse_phase = WAIT_HDR1;
        return 1'b0;
      end
      WAIT_HDR1: begin
        masked      = b[7];
        hdr_count   = 0;
        frame_len_q = '0;
        if (b[6:0] == LEN7_EXT16) begin
          parse_phase = WAIT_EXT16;
          return 1'b0;
        end
        if (b[6:0] == LEN7_EXT64) begin
          parse_phase = WAIT_EXT64;
          return 1'b0;
        end
        frame_len_q = {57'd0, b[6:0]};
        return length_done(r);
      end
      WAIT_EXT16, WAIT_EXT64: begin
        frame_len_q = {frame_len_q[55:0], b};
        hdr_count++;
        if (hdr_count == ((parse_phase == WAIT_EXT16) ? EXT16_BYTES : EXT64_BYTES))
          return length_done(r);
        return 1'b0;
      end
      WAIT_KEY: begin
        key_q = {key_q[23:0], b};
        hdr_count++;
        if (hdr_count == KEY_BYTES) return close_header(r);
        return 1'b0;
      end
      IN_PAYLOAD: begin
        // Key bytes are applied first key byte first, cycling every four bytes.
        shift     = 8 * (3 - int'(pay_idx[1:0]));
        key_byte  = masked ? 8'(key_q >> shift) : 8'h00;
        last_byte = ((pay_idx + 32'd1) == frame_len_q[31:0]);
        r.data_byte = b ^ key_byte;
        r.has_data  = 1'b1;
        r.opcode    = hdr_opcode;
        r.length    = frame_len_q[31:0];
        r.last      = last_byte;
        r.status    = STATUS_OK;
        pay_idx = pay_idx + 32'd1;
        if (last_byte) parse_phase = WAIT_HDR0;
        return 1'b1;
      end
      default: begin
        parse_phase = WAIT_HDR0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every output transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h, tuser %h, tlast %b", m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
        check_field("has_data", 32'(want.has_data), 32'(m_tuser[0]));
        check_field("frame_opcode", 32'(want.opcode), 32'(m_tdata[11:8]));
        check_field("frame_length", want.length, m_tdata[43:12]);
        check_field("last", 32'(want.last), 32'(m_tlast));
        check_field("status", 32'(want.status), 32'(m_tuser[2:1]));
      end
    end
  end

  // Output pacing: random stalls, plus a long hold when a test asks for one.
  always @(posedge clk) begin : sink_pacing
    if (sink_hold_req > 0) begin
      hold_left = sink_hold_req;
      sink_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_throttle && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one byte, waits for the transaction, then records its prediction.
  task automatic send_byte(input logic [7:0] b);
    frame_result_t r;
    int gap;
    int pick;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_results.push_back(r);
    gap = 0;
    if (src_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 97) gap = $urandom_range(10, 40);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the input and waits until every predicted result has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_PAYLOAD) max_bytes = value;
    else rx_enabled = value[0];
    @(posedge clk);
  endtask

  // Builds a frame with a random payload; optionally stops partway through.
  task automatic send_frame(input logic [7:0] first, input bit mask_on, input logic [63:0] len,
                            input int kind, input logic [31:0] key, input bit truncate);
    logic [7:0] bytes_q[$];
    int count;
    int i;
    bytes_q.push_back(first);
    case (kind)
      EXT_16: begin
        bytes_q.push_back({mask_on, LEN7_EXT16});
        bytes_q.push_back(len[15:8]);
        bytes_q.push_back(len[7:0]);
      end
      EXT_64: begin
        bytes_q.push_back({mask_on, LEN7_EXT64});
        for (i = 7; i >= 0; i--) bytes_q.push_back(len[8*i +: 8]);
      end
      default: bytes_q.push_back({mask_on, len[6:0]});
    endcase
    if (mask_on)
      for (i = 3; i >= 0; i--) bytes_q.push_back(key[8*i +: 8]);
    if (len <= 64'd1000)
      for (i = 0; i < int'(len); i++) bytes_q.push_back(8'($urandom));
    count = bytes_q.size();
    if (truncate && count > 1) count = $urandom_range(1, count - 1);
    for (i = 0; i < count; i++) send_byte(bytes_q[i]);
  endtask

  // Random byte that keeps any extended length below 256, so no overflow.
  function automatic logic [7:0] noise_byte();
    if (parse_phase == WAIT_EXT16 && hdr_count == 0) return 8'h00;
    if (parse_phase == WAIT_EXT64 && hdr_count < EXT64_BYTES - 1) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic resync();
    while (parse_phase != WAIT_HDR0) send_byte(noise_byte());
  endtask

  task automatic random_frame(input bit truncate);
    logic [63:0] len;
    int kind;
    int cap;
    int pick;
    cap  = (max_bytes < FRAME_CAP) ? int'(max_bytes) : FRAME_CAP;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      kind = EXT_NONE;
      len  = $urandom_range(0, (cap < 12) ? cap : 12);
    end else if (pick < 70) begin
      kind = EXT_NONE;
      len  = $urandom_range(0, (cap < 125) ? cap : 125);
    end else if (pick < 85) begin
      kind = EXT_16;
      len  = $urandom_range(0, cap);
    end else begin
      kind = EXT_64;
      len  = $urandom_range(0, cap);
    end
    send_frame(8'($urandom), 1'($urandom), len, kind, $urandom, truncate);
  endtask

  // Short frames in the 7-bit and 16-bit header forms, opcode extremes, masked and unmasked.
  task automatic test_basic_frames();
    send_frame(8'h89, 1'b0, 64'd0, EXT_NONE, 32'h0, 1'b0);
    send_frame(8'h81, 1'b1, 64'd3, EXT_NONE, 32'hFFFF_FFFF, 1'b0);
    send_frame(8'hFF, 1'b0, 64'd1, EXT_NONE, 32'h0, 1'b0);
    send_frame(8'h70, 1'b0, 64'd1, EXT_16, 32'h0, 1'b0);
    drain();
  endtask

  // Payload limit at zero, exactly at the limit, and raised during a header.
  task automatic test_limits();
    src_gaps = 1'b1;
    sink_throttle = 1'b1;
    write_reg(REG_MAX_PAYLOAD, 32'd0);
    send_frame(8'h88, 1'b0, 64'd0, EXT_NONE, 32'h0, 1'b0);
    drain();
    write_reg(REG_MAX_PAYLOAD, 32'd2);
    send_frame(8'h82, 1'b0, 64'd2, EXT_NONE, 32'h0, 1'b0);
    send_byte(8'h02);
    send_byte({1'b0, LEN7_EXT16});
    send_byte(8'h00);
    drain();
    write_reg(REG_MAX_PAYLOAD, 32'd3);
    send_byte(8'h03);
    repeat (3) send_byte(8'($urandom));
    drain();
    write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
  endtask

  // Disabling in the middle of a payload flags bytes and keeps the frame state.
  task automatic test_disabled();
    send_byte(8'h82);
    send_byte(8'h05);
    repeat (2) send_byte(8'($urandom));
    drain();
    write_reg(REG_ENABLED, 32'd0);
    repeat (4) send_byte(8'($urandom));
    drain();
    write_reg(REG_ENABLED, 32'd1);
    repeat (3) send_byte(8'($urandom));
    drain();
  endtask

  // Long output hold while a long frame streams in, so the input stalls.
  task automatic test_backpressure();
    src_gaps = 1'b0;
    sink_throttle = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    send_frame(8'h82, 1'b1, 64'd150, EXT_16, $urandom, 1'b0);
    drain();
  endtask

  // Random frames, noise and cut frames under a rotation of register settings.
  task automatic test_random_traffic();
    int goal;
    int seg;
    int seg_end;
    int pick;
    goal = bytes_sent + RANDOM_ITEMS;
    seg  = 0;
    while (bytes_sent < goal) begin
      src_gaps      = ($urandom_range(0, 3) != 0);
      sink_throttle = ($urandom_range(0, 3) != 0);
      if (seg % 5 == 4) begin
        write_reg(REG_ENABLED, 32'd0);
        repeat ($urandom_range(8, 30)) send_byte(8'($urandom));
        drain();
        write_reg(REG_ENABLED, 32'd1);
      end else begin
        case (seg % 5)
          0: write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
          1: write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
          2: write_reg(REG_MAX_PAYLOAD, $urandom_range(NOISE_MIN_MAX, 2000));
          default: write_reg(REG_MAX_PAYLOAD, $urandom_range(1, 40));
        endcase
        seg_end = bytes_sent + SEGMENT_ITEMS;
        while (bytes_sent < seg_end) begin
          pick = $urandom_range(0, 9);
          // Noise and cut frames only where a stray length cannot overflow.
          if (pick < 7 || max_bytes < NOISE_MIN_MAX) begin
            random_frame(1'b0);
          end else if (pick == 7) begin
            repeat ($urandom_range(1, 8)) send_byte(noise_byte());
            resync();
          end else begin
            random_frame(1'b1);
            resync();
          end
        end
        drain();
      end
      seg++;
    end
  endtask

  // Overflow with a saturated length, then the error state that drops bytes.
  task automatic test_overflow();
    src_gaps = 1'b1;
    sink_throttle = 1'b1;
    write_reg(REG_MAX_PAYLOAD, 32'hFFFF_FFFF);
    send_frame(8'h8A, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, EXT_64, $urandom, 1'b0);
    repeat (10) send_byte(8'($urandom));
    drain();
    write_reg(REG_ENABLED, 32'd0);
    repeat (5) send_byte(8'($urandom));
    drain();
    write_reg(REG_ENABLED, 32'd1);
    write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
    repeat (5) send_byte(8'($urandom));
    drain();
  endtask

  // Run-time limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_basic_frames();
    test_limits();
    test_disabled();
    test_backpressure();
    test_random_traffic();
    test_overflow();
    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
